// ----- sv/cbhd_pkg.sv -----
// shared types and constants for the cbor head decoder
package cbhd_pkg;

    localparam int FIFO_DEPTH = 4;

    typedef enum logic [1:0] {
        PH_IDLE = 2'd0,
        PH_ARG  = 2'd1,
        PH_PAY  = 2'd2,
        PH_SKIP = 2'd3
    } phase_t;

    typedef enum logic [1:0] {
        KIND_HEAD      = 2'd0,
        KIND_PAYLOAD   = 2'd1,
        KIND_ERROR     = 2'd2,
        KIND_FRAME_END = 2'd3
    } kind_t;

    typedef enum logic [2:0] {
        ERR_NONE          = 3'd0,
        ERR_RESERVED_AI   = 3'd1,
        ERR_NOT_SHORTEST  = 3'd2,
        ERR_TRUNC_HEAD    = 3'd3,
        ERR_TRUNC_PAYLOAD = 3'd4
    } err_t;

    localparam logic [2:0] MAJ_UINT = 3'd0;
    localparam logic [2:0] MAJ_NINT = 3'd1;
    localparam logic [2:0] MAJ_BSTR = 3'd2;
    localparam logic [2:0] MAJ_TSTR = 3'd3;

    localparam logic [4:0] AI_DIRECT_LIMIT = 5'd24;
    localparam logic [4:0] AI_ARG_MAX      = 5'd27;

    localparam logic [63:0] MAX_ONE_BYTE  = 64'h0000_0000_0000_00FF;
    localparam logic [63:0] MAX_TWO_BYTE  = 64'h0000_0000_0000_FFFF;
    localparam logic [63:0] MAX_FOUR_BYTE = 64'h0000_0000_FFFF_FFFF;

    typedef struct packed {
        kind_t       item_kind;
        logic [2:0]  major_type;
        logic [63:0] argument;
        logic [63:0] signed_result;
        logic        signed_valid;
        logic [7:0]  payload_byte;
        logic        payload_end;
        err_t        error_code;
        logic        run_last;
    } result_t;

endpackage

// ----- sv/cbhd_step.sv -----
// per-byte head parser: decode state and up to two results per item
module cbhd_step (
    input  logic              aclk,
    input  logic              aresetn,
    input  logic              in_fire,
    input  logic [7:0]        data_byte,
    input  logic              frame_last,
    output cbhd_pkg::result_t res0,
    output cbhd_pkg::result_t res1,
    output logic [1:0]        res_cnt
);

    localparam logic [63:0] AI_LIMIT_64 = {59'd0, cbhd_pkg::AI_DIRECT_LIMIT};

    cbhd_pkg::phase_t phase_reg, phase_next;
    logic [2:0]  held_major_reg, held_major_next;
    logic [3:0]  arg_bytes_left_reg, arg_bytes_left_next;
    logic [3:0]  arg_width_reg, arg_width_next;
    logic [63:0] arg_acc_reg, arg_acc_next;
    logic [63:0] payload_left_reg, payload_left_next;

    logic [4:0]  ai;
    logic [2:0]  cur_major;
    logic [63:0] acc_shift;
    logic [3:0]  bytes_dec;
    logic [63:0] pay_dec;
    logic        pay_end;
    logic        head_go;
    logic [63:0] head_arg;
    logic        head_str;
    logic        fail_go;
    cbhd_pkg::err_t fail_code;
    logic        arg_start;
    logic        pay_go;
    logic        longer;

    // decode of the current byte against the current phase
    always_comb begin
        ai        = data_byte[4:0];
        cur_major = (phase_reg == cbhd_pkg::PH_IDLE) ? data_byte[7:5] : held_major_reg;
        acc_shift = {arg_acc_reg[55:0], data_byte};
        bytes_dec = arg_bytes_left_reg - 4'd1;
        pay_dec   = payload_left_reg - 64'd1;
        pay_end   = (pay_dec == 64'd0);
        longer    = ((arg_width_reg == 4'd1) && (acc_shift < 64'(AI_LIMIT_64))) ||
                    ((arg_width_reg == 4'd2) && (acc_shift <= cbhd_pkg::MAX_ONE_BYTE)) ||
                    ((arg_width_reg == 4'd4) && (acc_shift <= cbhd_pkg::MAX_TWO_BYTE)) ||
                    ((arg_width_reg == 4'd8) && (acc_shift <= cbhd_pkg::MAX_FOUR_BYTE));
        head_go   = 1'b0;
        head_arg  = '0;
        fail_go   = 1'b0;
        fail_code = cbhd_pkg::ERR_NONE;
        arg_start = 1'b0;
        pay_go    = 1'b0;
        unique case (phase_reg)
            cbhd_pkg::PH_IDLE: begin
                priority if (ai < cbhd_pkg::AI_DIRECT_LIMIT) begin
                    head_go  = 1'b1;
                    head_arg = {59'd0, ai};
                end else if (ai > cbhd_pkg::AI_ARG_MAX) begin
                    fail_go   = 1'b1;
                    fail_code = cbhd_pkg::ERR_RESERVED_AI;
                end else begin
                    arg_start = 1'b1;
                    if (frame_last) begin
                        fail_go   = 1'b1;
                        fail_code = cbhd_pkg::ERR_TRUNC_HEAD;
                    end
                end
            end
            cbhd_pkg::PH_ARG: begin
                priority if (bytes_dec == 4'd0) begin
                    if (longer) begin
                        fail_go   = 1'b1;
                        fail_code = cbhd_pkg::ERR_NOT_SHORTEST;
                    end else begin
                        head_go  = 1'b1;
                        head_arg = acc_shift;
                    end
                end else if (frame_last) begin
                    fail_go   = 1'b1;
                    fail_code = cbhd_pkg::ERR_TRUNC_HEAD;
                end else begin
                    fail_go = 1'b0;
                end
            end
            cbhd_pkg::PH_PAY: begin
                pay_go = 1'b1;
            end
            cbhd_pkg::PH_SKIP: begin
                pay_go = 1'b0;
            end
            default: begin
                pay_go = 1'b0;
            end
        endcase
        head_str = ((cur_major == cbhd_pkg::MAJ_BSTR) || (cur_major == cbhd_pkg::MAJ_TSTR)) &&
                   (head_arg != 64'd0);
    end

    // next state
    always_comb begin
        phase_next          = phase_reg;
        held_major_next     = held_major_reg;
        arg_bytes_left_next = arg_bytes_left_reg;
        arg_width_next      = arg_width_reg;
        arg_acc_next        = arg_acc_reg;
        payload_left_next   = payload_left_reg;
        if (in_fire) begin
            if (phase_reg == cbhd_pkg::PH_IDLE) begin
                held_major_next = data_byte[7:5];
            end
            if (arg_start) begin
                // additional info 24..27 selects 1, 2, 4 or 8 argument bytes
                arg_width_next      = 4'(4'd1 << ai[1:0]);
                arg_bytes_left_next = 4'(4'd1 << ai[1:0]);
                arg_acc_next        = '0;
                phase_next          = cbhd_pkg::PH_ARG;
            end
            if (phase_reg == cbhd_pkg::PH_ARG) begin
                arg_acc_next        = acc_shift;
                arg_bytes_left_next = bytes_dec;
            end
            if (head_go) begin
                if (head_str) begin
                    payload_left_next = head_arg;
                    phase_next = frame_last ? cbhd_pkg::PH_IDLE : cbhd_pkg::PH_PAY;
                end else begin
                    phase_next = cbhd_pkg::PH_IDLE;
                end
            end
            if (pay_go) begin
                payload_left_next = pay_dec;
                phase_next = (pay_end || frame_last) ? cbhd_pkg::PH_IDLE : cbhd_pkg::PH_PAY;
            end
            if (fail_go) begin
                phase_next = frame_last ? cbhd_pkg::PH_IDLE : cbhd_pkg::PH_SKIP;
            end
            if ((phase_reg == cbhd_pkg::PH_SKIP) && frame_last) begin
                phase_next = cbhd_pkg::PH_IDLE;
            end
        end
    end

    // results for this item
    always_comb begin
        res0    = '0;
        res1    = '0;
        res_cnt = 2'd0;
        if (head_go) begin
            res0.item_kind  = cbhd_pkg::KIND_HEAD;
            res0.major_type = cur_major;
            res0.argument   = head_arg;
            if (((cur_major == cbhd_pkg::MAJ_UINT) || (cur_major == cbhd_pkg::MAJ_NINT)) &&
                !head_arg[63]) begin
                res0.signed_valid  = 1'b1;
                res0.signed_result = (cur_major == cbhd_pkg::MAJ_UINT) ? head_arg : ~head_arg;
            end
            res_cnt = 2'd1;
            if (frame_last) begin
                res_cnt = 2'd2;
                if (head_str) begin
                    res1.item_kind  = cbhd_pkg::KIND_ERROR;
                    res1.major_type = cur_major;
                    res1.error_code = cbhd_pkg::ERR_TRUNC_PAYLOAD;
                end else begin
                    res1.item_kind = cbhd_pkg::KIND_FRAME_END;
                end
            end
        end
        if (fail_go) begin
            res0.item_kind  = cbhd_pkg::KIND_ERROR;
            res0.major_type = cur_major;
            res0.error_code = fail_code;
            res_cnt         = 2'd1;
        end
        if (pay_go) begin
            res0.item_kind    = cbhd_pkg::KIND_PAYLOAD;
            res0.major_type   = held_major_reg;
            res0.payload_byte = data_byte;
            res0.payload_end  = pay_end;
            res_cnt           = 2'd1;
            if (frame_last) begin
                res_cnt = 2'd2;
                if (pay_end) begin
                    res1.item_kind = cbhd_pkg::KIND_FRAME_END;
                end else begin
                    res1.item_kind  = cbhd_pkg::KIND_ERROR;
                    res1.major_type = held_major_reg;
                    res1.error_code = cbhd_pkg::ERR_TRUNC_PAYLOAD;
                end
            end
        end
        res0.run_last = (res_cnt == 2'd1);
        res1.run_last = 1'b1;
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            phase_reg          <= cbhd_pkg::PH_IDLE;
            held_major_reg     <= '0;
            arg_bytes_left_reg <= '0;
            arg_width_reg      <= '0;
            arg_acc_reg        <= '0;
            payload_left_reg   <= '0;
        end else begin
            phase_reg          <= phase_next;
            held_major_reg     <= held_major_next;
            arg_bytes_left_reg <= arg_bytes_left_next;
            arg_width_reg      <= arg_width_next;
            arg_acc_reg        <= arg_acc_next;
            payload_left_reg   <= payload_left_next;
        end
    end

endmodule

// ----- sv/cbhd_out_fifo.sv -----
// result queue: takes up to two results a cycle, hands out one
module cbhd_out_fifo #(
    parameter int DEPTH = cbhd_pkg::FIFO_DEPTH
) (
    input  logic              aclk,
    input  logic              aresetn,
    input  cbhd_pkg::result_t res0,
    input  cbhd_pkg::result_t res1,
    input  logic [1:0]        push_cnt,
    output logic              room,
    output cbhd_pkg::result_t head,
    output logic              m_valid,
    input  logic              m_ready
);

    localparam int PTR_W = $clog2(DEPTH);
    localparam int CNT_W = $clog2(DEPTH + 1);
    localparam logic [CNT_W-1:0] ROOM_MAX = CNT_W'(DEPTH - 2);
    localparam logic [CNT_W-1:0] FULL     = CNT_W'(DEPTH);

    cbhd_pkg::result_t mem [DEPTH];
    logic [PTR_W-1:0] wr_ptr_reg, wr_ptr_next;
    logic [PTR_W-1:0] rd_ptr_reg, rd_ptr_next;
    logic [CNT_W-1:0] count_reg, count_next;
    logic             pop;

    assign m_valid = (count_reg != '0);
    assign pop     = m_valid && m_ready;
    assign room    = (count_reg <= ROOM_MAX);
    assign head    = mem[rd_ptr_reg];

    always_comb begin
        wr_ptr_next = wr_ptr_reg + PTR_W'(push_cnt);
        rd_ptr_next = rd_ptr_reg + PTR_W'(pop);
        count_next  = count_reg + CNT_W'(push_cnt) - CNT_W'(pop);
    end

    always_ff @(posedge aclk) begin
        if (push_cnt != 2'd0) begin
            mem[wr_ptr_reg] <= res0;
        end
        if (push_cnt == 2'd2) begin
            mem[wr_ptr_reg + PTR_W'(1)] <= res1;
        end
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            wr_ptr_reg <= '0;
            rd_ptr_reg <= '0;
            count_reg  <= '0;
        end else begin
            wr_ptr_reg <= wr_ptr_next;
            rd_ptr_reg <= rd_ptr_next;
            count_reg  <= count_next;
        end
    end

    a_count_bound : assert property (@(posedge aclk) disable iff (!aresetn)
        count_reg <= FULL)
        else $error("result queue over capacity");

    a_push_room : assert property (@(posedge aclk) disable iff (!aresetn)
        (push_cnt != 2'd0) |-> room)
        else $error("results pushed without room");

    a_count_track : assert property (@(posedge aclk) disable iff (!aresetn)
        1'b1 |=> (count_reg == $past(count_reg) + CNT_W'($past(push_cnt)) - CNT_W'($past(pop))))
        else $error("queue count lost track");

    a_ptr_gap : assert property (@(posedge aclk) disable iff (!aresetn)
        (count_reg != FULL) |-> (PTR_W'(wr_ptr_reg - rd_ptr_reg) == PTR_W'(count_reg)))
        else $error("queue pointers disagree with count");

endmodule

// ----- sv/cbor_head_decoder_unit.sv -----
// top level of the cbor head decoder
//
//  channel | direction | ports                                   | carries
//  s_      | in        | s_valid s_ready s_data_byte s_frame_last | one stream byte per item
//  m_      | out       | m_valid m_ready m_item_kind ...          | heads, payload, errors
//
// each byte is parsed in the cycle it is accepted; its zero, one or two results enter
// a queue of FIFO_DEPTH entries and leave one per cycle while m_ready is high, so a byte
// that yields one result sustains one byte per clock; otherwise the queue drain sets it.
// s_ready falls while the queue cannot take two more results.
// reset (aresetn low, synchronous) empties the queue and returns to expecting an
// initial byte.
module cbor_head_decoder_unit #(
    parameter int FIFO_DEPTH = cbhd_pkg::FIFO_DEPTH
) (
    input  logic               aclk,
    input  logic               aresetn,
    input  logic               s_valid,
    output logic               s_ready,
    input  logic [7:0]         s_data_byte,
    input  logic               s_frame_last,
    output logic               m_valid,
    input  logic               m_ready,
    output logic [1:0]         m_item_kind,
    output logic [2:0]         m_major_type,
    output logic [63:0]        m_argument,
    output logic signed [63:0] m_signed_result,
    output logic               m_signed_valid,
    output logic [7:0]         m_payload_byte,
    output logic               m_payload_end,
    output logic [2:0]         m_error_code,
    output logic               m_run_last
);

    cbhd_pkg::result_t res0, res1, head;
    logic [1:0] res_cnt;
    logic [1:0] push_cnt;
    logic       in_fire;
    logic       room;

    assign s_ready  = room;
    assign in_fire  = s_valid && room;
    assign push_cnt = in_fire ? res_cnt : 2'd0;

    cbhd_step u_step (
        .aclk       (aclk),
        .aresetn    (aresetn),
        .in_fire    (in_fire),
        .data_byte  (s_data_byte),
        .frame_last (s_frame_last),
        .res0       (res0),
        .res1       (res1),
        .res_cnt    (res_cnt)
    );

    cbhd_out_fifo #(
        .DEPTH (FIFO_DEPTH)
    ) u_out_fifo (
        .aclk     (aclk),
        .aresetn  (aresetn),
        .res0     (res0),
        .res1     (res1),
        .push_cnt (push_cnt),
        .room     (room),
        .head     (head),
        .m_valid  (m_valid),
        .m_ready  (m_ready)
    );

    assign m_item_kind     = head.item_kind;
    assign m_major_type    = head.major_type;
    assign m_argument      = head.argument;
    assign m_signed_result = $signed(head.signed_result);
    assign m_signed_valid  = head.signed_valid;
    assign m_payload_byte  = head.payload_byte;
    assign m_payload_end   = head.payload_end;
    assign m_error_code    = head.error_code;
    assign m_run_last      = head.run_last;

endmodule

// ----- tb/sv/cbhd_result_checker.sv -----
// result checker for the cbor head decoder: decodes accepted bytes and compares results
`timescale 1ns / 100ps

module cbhd_result_checker
    import cbhd_pkg::*;
(
    input  logic               aclk,
    input  logic               aresetn,
    input  logic               s_valid,
    input  logic               s_ready,
    input  logic [7:0]         s_data_byte,
    input  logic               s_frame_last,
    input  logic               m_valid,
    input  logic               m_ready,
    input  logic [1:0]         m_item_kind,
    input  logic [2:0]         m_major_type,
    input  logic [63:0]        m_argument,
    input  logic signed [63:0] m_signed_result,
    input  logic               m_signed_valid,
    input  logic [7:0]         m_payload_byte,
    input  logic               m_payload_end,
    input  logic [2:0]         m_error_code,
    input  logic               m_run_last,
    output int                 errors_seen,
    output int                 results_owed
);

    phase_t      dec_phase;
    logic [2:0]  dec_major;
    logic [3:0]  dec_left;
    logic [3:0]  dec_width;
    logic [63:0] dec_acc;
    logic [63:0] dec_pay_left;

    result_t     owed_results[$];
    result_t     byte_results[2];
    int          byte_result_count;
    int          fail_tally = 0;

    function automatic result_t blank_result(kind_t kind, logic [2:0] maj);
        result_t r;
        r = '0;
        r.item_kind  = kind;
        r.major_type = maj;
        return r;
    endfunction

    task automatic emit(result_t r);
        byte_results[byte_result_count] = r;
        byte_result_count++;
    endtask

    task automatic raise_error(err_t code, logic lst);
        result_t r;
        r = blank_result(KIND_ERROR, dec_major);
        r.error_code = code;
        emit(r);
        // an error on the final byte leaves nothing to discard
        dec_phase = lst ? PH_IDLE : PH_SKIP;
    endtask

    task automatic close_head(logic [63:0] arg, logic lst);
        result_t r;
        r = blank_result(KIND_HEAD, dec_major);
        r.argument = arg;
        if ((dec_major == MAJ_UINT || dec_major == MAJ_NINT) && !arg[63]) begin
            r.signed_valid  = 1'b1;
            r.signed_result = (dec_major == MAJ_UINT) ? arg : ~arg;
        end
        emit(r);
        if ((dec_major == MAJ_BSTR || dec_major == MAJ_TSTR) && arg != '0) begin
            dec_pay_left = arg;
            dec_phase    = PH_PAY;
            if (lst) begin
                raise_error(ERR_TRUNC_PAYLOAD, 1'b1);
            end
        end else begin
            dec_phase = PH_IDLE;
            if (lst) begin
                emit(blank_result(KIND_FRAME_END, '0));
            end
        end
    endtask

    task automatic decode_byte(logic [7:0] b, logic lst);
        result_t r;
        logic    padded;
        byte_result_count = 0;
        case (dec_phase)
            PH_IDLE: begin
                dec_major = b[7:5];
                if (b[4:0] < AI_DIRECT_LIMIT) begin
                    close_head(64'(b[4:0]), lst);
                end else if (b[4:0] > AI_ARG_MAX) begin
                    raise_error(ERR_RESERVED_AI, lst);
                end else begin
                    dec_width = 4'd1 << (b[4:0] - AI_DIRECT_LIMIT);
                    dec_left  = dec_width;
                    dec_acc   = '0;
                    dec_phase = PH_ARG;
                    if (lst) begin
                        raise_error(ERR_TRUNC_HEAD, 1'b1);
                    end
                end
            end
            PH_ARG: begin
                dec_acc  = {dec_acc[55:0], b};
                dec_left = dec_left - 4'd1;
                if (dec_left == '0) begin
                    // a value that would fit a narrower encoding is rejected
                    case (dec_width)
                        4'd1:    padded = dec_acc < AI_DIRECT_LIMIT;
                        4'd2:    padded = dec_acc <= MAX_ONE_BYTE;
                        4'd4:    padded = dec_acc <= MAX_TWO_BYTE;
                        default: padded = dec_acc <= MAX_FOUR_BYTE;
                    endcase
                    if (padded) begin
                        raise_error(ERR_NOT_SHORTEST, lst);
                    end else begin
                        close_head(dec_acc, lst);
                    end
                end else if (lst) begin
                    raise_error(ERR_TRUNC_HEAD, 1'b1);
                end
            end
            PH_PAY: begin
                dec_pay_left    = dec_pay_left - 64'd1;
                r               = blank_result(KIND_PAYLOAD, dec_major);
                r.payload_byte  = b;
                r.payload_end   = (dec_pay_left == '0);
                emit(r);
                if (dec_pay_left == '0) begin
                    dec_phase = PH_IDLE;
                    if (lst) begin
                        emit(blank_result(KIND_FRAME_END, '0));
                    end
                end else if (lst) begin
                    raise_error(ERR_TRUNC_PAYLOAD, 1'b1);
                end
            end
            default: begin
                if (lst) begin
                    dec_phase = PH_IDLE;
                end
            end
        endcase
        if (byte_result_count > 0) begin
            byte_results[byte_result_count - 1].run_last = 1'b1;
        end
        for (int i = 0; i < byte_result_count; i++) begin
            owed_results.push_back(byte_results[i]);
        end
    endtask

    task automatic check_field(string name, logic [63:0] want, logic [63:0] got);
        if (want !== got) begin
            $display("%0t: %s expected %h, got %h", $time, name, want, got);
            fail_tally++;
        end
    endtask

    always @(posedge aclk) begin
        result_t want;
        if (!aresetn) begin
            dec_phase    = PH_IDLE;
            dec_major    = '0;
            dec_left     = '0;
            dec_width    = '0;
            dec_acc      = '0;
            dec_pay_left = '0;
            owed_results.delete();
        end else begin
            if (s_valid && s_ready) begin
                decode_byte(s_data_byte, s_frame_last);
            end
            if (m_valid && m_ready) begin
                if (owed_results.size() == 0) begin
                    $display("%0t: result with nothing owed, expected none, got kind %0d major %0d",
                             $time, m_item_kind, m_major_type);
                    fail_tally++;
                end else begin
                    want = owed_results.pop_front();
                    check_field("item_kind", 64'(want.item_kind), 64'(m_item_kind));
                    check_field("major_type", 64'(want.major_type), 64'(m_major_type));
                    check_field("argument", want.argument, m_argument);
                    check_field("signed_result", want.signed_result, 64'(m_signed_result));
                    check_field("signed_valid", 64'(want.signed_valid), 64'(m_signed_valid));
                    check_field("payload_byte", 64'(want.payload_byte), 64'(m_payload_byte));
                    check_field("payload_end", 64'(want.payload_end), 64'(m_payload_end));
                    check_field("error_code", 64'(want.error_code), 64'(m_error_code));
                    check_field("run_last", 64'(want.run_last), 64'(m_run_last));
                end
            end
        end
        errors_seen  <= fail_tally;
        results_owed <= owed_results.size();
    end

endmodule

// ----- tb/sv/tb_top.sv -----
// testbench top for the cbor head decoder: clock, reset, byte stream and verdict
`timescale 1ns / 100ps

module tb_top;
    import cbhd_pkg::*;

    localparam int CLK_PERIOD   = 12;
    localparam int STALL_LIMIT  = 2000;
    localparam int LONG_HOLD    = 250;
    localparam int DRAIN_CYCLES = 20;
    localparam int PHASE_ITEMS  = 660;

    logic               aclk = 1'b0;
    logic               aresetn = 1'b0;
    logic               s_valid = 1'b0;
    logic               s_ready;
    logic [7:0]         s_data_byte = '0;
    logic               s_frame_last = 1'b0;
    logic               m_valid;
    logic               m_ready = 1'b0;
    logic [1:0]         m_item_kind;
    logic [2:0]         m_major_type;
    logic [63:0]        m_argument;
    logic signed [63:0] m_signed_result;
    logic               m_signed_valid;
    logic [7:0]         m_payload_byte;
    logic               m_payload_end;
    logic [2:0]         m_error_code;
    logic               m_run_last;

    int                 errors_seen;
    int                 results_owed;

    int                 send_idle_pct = 25;
    int                 recv_idle_pct = 63;
    int                 holds_asked = 0;
    int                 holds_done = 0;
    int                 hold_left = 0;
    int                 idle_cycles = 0;
    int                 bytes_counted = 0;
    logic [7:0]         frame_q[$];

    always #(CLK_PERIOD / 2) aclk = ~aclk;

    cbor_head_decoder_unit dut (
        .aclk            (aclk),
        .aresetn         (aresetn),
        .s_valid         (s_valid),
        .s_ready         (s_ready),
        .s_data_byte     (s_data_byte),
        .s_frame_last    (s_frame_last),
        .m_valid         (m_valid),
        .m_ready         (m_ready),
        .m_item_kind     (m_item_kind),
        .m_major_type    (m_major_type),
        .m_argument      (m_argument),
        .m_signed_result (m_signed_result),
        .m_signed_valid  (m_signed_valid),
        .m_payload_byte  (m_payload_byte),
        .m_payload_end   (m_payload_end),
        .m_error_code    (m_error_code),
        .m_run_last      (m_run_last)
    );

    cbhd_result_checker u_checker (
        .aclk            (aclk),
        .aresetn         (aresetn),
        .s_valid         (s_valid),
        .s_ready         (s_ready),
        .s_data_byte     (s_data_byte),
        .s_frame_last    (s_frame_last),
        .m_valid         (m_valid),
        .m_ready         (m_ready),
        .m_item_kind     (m_item_kind),
        .m_major_type    (m_major_type),
        .m_argument      (m_argument),
        .m_signed_result (m_signed_result),
        .m_signed_valid  (m_signed_valid),
        .m_payload_byte  (m_payload_byte),
        .m_payload_end   (m_payload_end),
        .m_error_code    (m_error_code),
        .m_run_last      (m_run_last),
        .errors_seen     (errors_seen),
        .results_owed    (results_owed)
    );

    // receiver: random back-pressure, plus a long hold-off when one is asked for
    always @(posedge aclk) begin
        if (holds_done != holds_asked) begin
            holds_done = holds_asked;
            hold_left  = LONG_HOLD;
        end
        if (hold_left > 0) begin
            hold_left--;
            m_ready <= 1'b0;
        end else begin
            m_ready <= ($urandom_range(99) >= recv_idle_pct);
        end
    end

    always @(posedge aclk) begin
        if (!aresetn || (s_valid && s_ready) || (m_valid && m_ready)) begin
            idle_cycles <= 0;
        end else if (idle_cycles >= STALL_LIMIT) begin
            $display("Test completed with failures");
            $finish;
        end else begin
            idle_cycles <= idle_cycles + 1;
        end
    end

    // argument bytes, most significant first
    task automatic put_arg(logic [4:0] ai, logic [63:0] v);
        for (int i = (1 << (ai - AI_DIRECT_LIMIT)) - 1; i >= 0; i--) begin
            frame_q.push_back(v[8*i +: 8]);
        end
    endtask

    task automatic put_head(logic [2:0] maj, logic [63:0] v);
        logic [4:0] ai;
        if (v < AI_DIRECT_LIMIT) begin
            ai = v[4:0];
        end else if (v <= MAX_ONE_BYTE) begin
            ai = AI_DIRECT_LIMIT;
        end else if (v <= MAX_TWO_BYTE) begin
            ai = AI_DIRECT_LIMIT + 5'd1;
        end else if (v <= MAX_FOUR_BYTE) begin
            ai = AI_DIRECT_LIMIT + 5'd2;
        end else begin
            ai = AI_ARG_MAX;
        end
        frame_q.push_back({maj, ai});
        if (ai >= AI_DIRECT_LIMIT) begin
            put_arg(ai, v);
        end
    endtask

    // one well-formed data item, strings kept mostly short
    task automatic put_item();
        logic [2:0]  maj;
        logic [63:0] v;
        int          len;
        int          r;
        maj = 3'($urandom_range(7));
        r   = $urandom_range(99);
        if (maj == MAJ_BSTR || maj == MAJ_TSTR) begin
            len = (r < 75) ? $urandom_range(12) :
                  (r < 97) ? $urandom_range(60, 13) : $urandom_range(300, 256);
            put_head(maj, 64'(len));
            repeat (len) frame_q.push_back(8'($urandom));
        end else begin
            case ($urandom_range(5))
                0: v = 64'($urandom_range(23));
                1: v = 64'($urandom_range(255, 24));
                2: v = 64'($urandom_range(65535, 256));
                3: v = {32'd0, $urandom | 32'h0001_0000};
                4: begin
                    v = {$urandom, $urandom};
                    if (v[63:32] == '0) begin
                        v[32] = 1'b1;
                    end
                end
                default: begin
                    // the int64 boundary and the widest values
                    case ($urandom_range(4))
                        0: v = 64'h7FFF_FFFF_FFFF_FFFF;
                        1: v = 64'h8000_0000_0000_0000;
                        2: v = '1;
                        3: v = 64'h0000_0001_0000_0000;
                        default: v = MAX_FOUR_BYTE;
                    endcase
                end
            endcase
            put_head(maj, v);
        end
    endtask

    // bytes discarded after an error are not counted
    task automatic send_frame(int ignored);
        for (int i = 0; i < frame_q.size(); i++) begin
            while ($urandom_range(99) < send_idle_pct) begin
                s_valid <= 1'b0;
                @(posedge aclk);
            end
            s_valid      <= 1'b1;
            s_data_byte  <= frame_q[i];
            s_frame_last <= (i == frame_q.size() - 1);
            @(posedge aclk);
            while (!s_ready) @(posedge aclk);
        end
        bytes_counted += frame_q.size() - ignored;
        frame_q.delete();
    endtask

    initial begin
        int          goal;
        int          sel;
        int          junk;
        int          len;
        logic [4:0]  ai;
        logic [63:0] v;

        repeat (5) @(posedge aclk);
        aresetn <= 1'b1;
        @(posedge aclk);

        // zero with a clean frame end
        frame_q = '{8'h00};
        send_frame(0);
        // negative with the widest argument, outside int64
        frame_q = '{8'h3b, 8'hff, 8'hff, 8'hff, 8'hff, 8'hff, 8'hff, 8'hff, 8'hff};
        send_frame(0);
        // reserved additional info on the final byte
        frame_q = '{8'h1c};
        send_frame(0);
        // padded argument, then a discarded byte closing the frame
        frame_q = '{8'h18, 8'h05, 8'h00};
        send_frame(1);
        // frame ends inside a head
        frame_q = '{8'h19, 8'h01};
        send_frame(0);
        // empty byte string, then a text string cut short
        frame_q = '{8'h40, 8'h62, 8'h61};
        send_frame(0);
        // one-byte text string closing the frame
        frame_q = '{8'h61, 8'hff};
        send_frame(0);

        for (int ph = 0; ph < 3; ph++) begin
            send_idle_pct = (ph == 0) ? 25 : (ph == 1) ? 63 : 0;
            recv_idle_pct = (ph == 0) ? 63 : (ph == 1) ? 25 : 0;
            if (ph != 1) begin
                holds_asked++;
            end
            goal = bytes_counted + PHASE_ITEMS;
            while (bytes_counted < goal) begin
                junk = 0;
                repeat ($urandom_range(3)) put_item();
                sel = $urandom_range(99);
                if (sel < 55) begin
                    put_item();
                end else if (sel < 65) begin
                    frame_q.push_back({3'($urandom), 5'($urandom_range(31, 28))});
                    junk = $urandom_range(5);
                end else if (sel < 75) begin
                    // argument that fits a shorter form
                    ai = 5'($urandom_range(AI_ARG_MAX, AI_DIRECT_LIMIT));
                    case (ai - AI_DIRECT_LIMIT)
                        5'd0:    v = 64'($urandom_range(23));
                        5'd1:    v = 64'($urandom_range(255));
                        5'd2:    v = 64'($urandom_range(65535));
                        default: v = 64'($urandom);
                    endcase
                    frame_q.push_back({3'($urandom), ai});
                    put_arg(ai, v);
                    junk = $urandom_range(5);
                end else if (sel < 83) begin
                    // head cut short by the frame end
                    ai = 5'($urandom_range(AI_ARG_MAX, AI_DIRECT_LIMIT));
                    frame_q.push_back({3'($urandom), ai});
                    put_arg(ai, {$urandom, $urandom});
                    repeat ($urandom_range(1 << (ai - AI_DIRECT_LIMIT), 1)) frame_q.pop_back();
                end else if (sel < 91) begin
                    // string payload cut short by the frame end
                    len = $urandom_range(20, 1);
                    put_head($urandom_range(1) ? MAJ_BSTR : MAJ_TSTR, 64'(len));
                    repeat ($urandom_range(len - 1)) frame_q.push_back(8'($urandom));
                end else begin
                    repeat ($urandom_range(12, 1)) frame_q.push_back(8'($urandom));
                end
                repeat (junk) frame_q.push_back(8'($urandom));
                send_frame(junk);
            end
        end
        s_valid <= 1'b0;

        // the owed count is registered, so it lags the last accepted byte
        @(posedge aclk);
        while (results_owed != 0) @(posedge aclk);
        repeat (DRAIN_CYCLES) @(posedge aclk);
        if (errors_seen == 0 && results_owed == 0) begin
            $display("Test completed successfully");
        end else begin
            $display("Test completed with failures");
        end
        $finish;
    end

endmodule
